[hdl/mat3_inverse_cofactor_unit_assert.svh]
// Assertion macros for the 3x3 matrix inverse unit.
`ifndef MAT3_INVERSE_COFACTOR_UNIT_ASSERT_SVH
`define MAT3_INVERSE_COFACTOR_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define M3INV_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("m3inv implication check failed");
`define M3INV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("m3inv next-cycle check failed");
`else
`define M3INV_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define M3INV_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[hdl/m3inv_pkg.sv]
// Shared types and constants for the 3x3 matrix inverse unit.
package m3inv_pkg;

  localparam int unsigned NumEntries = 9;
  localparam int unsigned QuotBits   = 32;

  typedef logic signed [15:0] entry_t;
  typedef logic signed [31:0] prod_t;
  typedef logic signed [31:0] cof_t;
  typedef logic signed [47:0] dprod_t;
  typedef logic signed [49:0] det_t;
  typedef logic        [47:0] mag_t;
  typedef logic signed [31:0] inv_t;
  typedef logic        [3:0]  idx_t;

  typedef entry_t [NumEntries-1:0] mat_t;
  typedef cof_t   [NumEntries-1:0] adj_t;

  // Cofactor k = m[PA]*m[PB] - m[NA]*m[NB], row-major adjugate order.
  localparam idx_t COF_PA [NumEntries] = '{4'd4, 4'd2, 4'd1, 4'd5, 4'd0, 4'd2, 4'd3, 4'd1, 4'd0};
  localparam idx_t COF_PB [NumEntries] = '{4'd8, 4'd7, 4'd5, 4'd6, 4'd8, 4'd3, 4'd7, 4'd6, 4'd4};
  localparam idx_t COF_NA [NumEntries] = '{4'd5, 4'd1, 4'd2, 4'd3, 4'd2, 4'd0, 4'd4, 4'd0, 4'd1};
  localparam idx_t COF_NB [NumEntries] = '{4'd7, 4'd8, 4'd4, 4'd8, 4'd6, 4'd5, 4'd6, 4'd7, 4'd3};

  localparam inv_t INV_MAX = 32'sh7FFF_FFFF;
  localparam inv_t INV_MIN = 32'sh8000_0000;

endpackage

[hdl/m3inv_cofactor.sv]
// Two pipeline stages: the eighteen minor products, then the nine cofactors.
module m3inv_cofactor
  import m3inv_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  input  mat_t mat_i,
  output logic valid_o,
  output mat_t mat_o,
  output adj_t adj_o
);

  prod_t pos_q [NumEntries];
  prod_t neg_q [NumEntries];
  mat_t  mat1_q, mat2_q;
  adj_t  adj_q;
  logic  v1_q, v2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NumEntries; k++) begin
      pos_q[k] <= mat_i[COF_PA[k]] * mat_i[COF_PB[k]];
      neg_q[k] <= mat_i[COF_NA[k]] * mat_i[COF_NB[k]];
      adj_q[k] <= pos_q[k] - neg_q[k];
    end
    mat1_q <= mat_i;
    mat2_q <= mat1_q;
  end

  assign valid_o = v2_q;
  assign mat_o   = mat2_q;
  assign adj_o   = adj_q;

endmodule

[hdl/m3inv_det.sv]
// Two pipeline stages: first-row expansion products, then the determinant,
// its magnitude and the singular test.
module m3inv_det
  import m3inv_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  input  mat_t mat_i,
  input  adj_t adj_i,
  input  mag_t tol_i,
  output logic valid_o,
  output adj_t adj_o,
  output mag_t dmag_o,
  output logic dneg_o,
  output logic sing_o
);

  dprod_t dp_q [3];
  adj_t   adj1_q, adj2_q;
  logic   v1_q, v2_q;
  mag_t   dmag_q;
  logic   dneg_q, sing_q;
  det_t   det;
  mag_t   dmag;

  assign det = det_t'(dp_q[0]) + det_t'(dp_q[1]) + det_t'(dp_q[2]);
  assign dmag = det[49] ? mag_t'(-det) : mag_t'(det);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    dp_q[0] <= dprod_t'(mat_i[0]) * dprod_t'(adj_i[0]);
    dp_q[1] <= dprod_t'(mat_i[1]) * dprod_t'(adj_i[3]);
    dp_q[2] <= dprod_t'(mat_i[2]) * dprod_t'(adj_i[6]);
    adj1_q  <= adj_i;
    adj2_q  <= adj1_q;
    dmag_q  <= dmag;
    dneg_q  <= det[49];
    sing_q  <= (dmag <= tol_i);
  end

  assign valid_o = v2_q;
  assign adj_o   = adj2_q;
  assign dmag_o  = dmag_q;
  assign dneg_o  = dneg_q;
  assign sing_o  = sing_q;

endmodule

[hdl/m3inv_div_lane.sv]
// One divide lane: rounded cofactor/determinant quotient, one bit a stage,
// with saturation to signed Q0.32 (32 fractional bits).
module m3inv_div_lane
  import m3inv_pkg::*;
(
  input  logic clk_i,
  input  cof_t cof_i,
  input  mag_t dmag_i,
  input  logic dneg_i,
  output inv_t inv_o,
  output logic clip_o
);

  logic [47:0] rem_q  [QuotBits+1];
  logic [31:0] low_q  [QuotBits+1];
  logic [31:0] quo_q  [QuotBits+1];
  mag_t        d_q    [QuotBits+1];
  logic        neg_q  [QuotBits+1];
  logic        over_q [QuotBits+1];

  logic [31:0] cmag;
  mag_t        half;

  assign cmag = cof_i[31] ? 32'(-cof_i) : 32'(cof_i);
  assign half = dmag_i >> 1;

  // Entry stage: numerator is |c|*2^32 + floor(|det|/2); the quotient
  // overflows 32 bits exactly when |c| >= |det|.
  always_ff @(posedge clk_i) begin
    rem_q[0]  <= {16'b0, cmag} + {33'b0, half[46:32]};
    low_q[0]  <= half[31:0];
    quo_q[0]  <= '0;
    d_q[0]    <= dmag_i;
    neg_q[0]  <= cof_i[31] ^ dneg_i;
    over_q[0] <= ({16'b0, cmag} >= dmag_i);
  end

  for (genvar k = 0; k < QuotBits; k++) begin : g_stage
    logic [48:0] trial;
    assign trial = {rem_q[k], low_q[k][QuotBits-1-k]} - {1'b0, d_q[k]};
    always_ff @(posedge clk_i) begin
      rem_q[k+1]  <= trial[48] ? {rem_q[k][46:0], low_q[k][QuotBits-1-k]} : trial[47:0];
      quo_q[k+1]  <= {quo_q[k][30:0], ~trial[48]};
      low_q[k+1]  <= low_q[k];
      d_q[k+1]    <= d_q[k];
      neg_q[k+1]  <= neg_q[k];
      over_q[k+1] <= over_q[k];
    end
  end

  always_comb begin
    logic [31:0] q;
    q = quo_q[QuotBits];
    clip_o = 1'b0;
    if (over_q[QuotBits]) begin
      clip_o = 1'b1;
      inv_o  = neg_q[QuotBits] ? INV_MIN : INV_MAX;
    end else if (!neg_q[QuotBits]) begin
      if (q > 32'h7FFF_FFFF) begin
        clip_o = 1'b1;
        inv_o  = INV_MAX;
      end else begin
        inv_o = inv_t'(q);
      end
    end else begin
      if (q > 32'h8000_0000) begin
        clip_o = 1'b1;
        inv_o  = INV_MIN;
      end else begin
        inv_o = inv_t'(-q);
      end
    end
  end

endmodule

[hdl/mat3_inverse_cofactor_unit.sv]
// Top level of the 3x3 matrix inverse unit (adjugate over determinant).
// A matrix passes the cofactor, determinant, divide-lane and output registers in order.
// Throughput: one matrix per cycle; busy is always low since the
// pipeline never stalls and the receiver cannot hold results off.
// Depth is set by the 32 one-bit stages of the nine divide lanes.
// Reset clears all valid bits and the tolerance register; no clearing pass.
`include "mat3_inverse_cofactor_unit_assert.svh"
module mat3_inverse_cofactor_unit
  import m3inv_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  output logic               done_o,
  input  logic signed [15:0] m_r0c0_i,
  input  logic signed [15:0] m_r0c1_i,
  input  logic signed [15:0] m_r0c2_i,
  input  logic signed [15:0] m_r1c0_i,
  input  logic signed [15:0] m_r1c1_i,
  input  logic signed [15:0] m_r1c2_i,
  input  logic signed [15:0] m_r2c0_i,
  input  logic signed [15:0] m_r2c1_i,
  input  logic signed [15:0] m_r2c2_i,
  output logic signed [31:0] inv_r0c0_o,
  output logic signed [31:0] inv_r0c1_o,
  output logic signed [31:0] inv_r0c2_o,
  output logic signed [31:0] inv_r1c0_o,
  output logic signed [31:0] inv_r1c1_o,
  output logic signed [31:0] inv_r1c2_o,
  output logic signed [31:0] inv_r2c0_o,
  output logic signed [31:0] inv_r2c1_o,
  output logic signed [31:0] inv_r2c2_o,
  output logic               invertible_o,
  output logic               clipped_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready
);

  localparam int unsigned LaneDepth = QuotBits + 1;

  // Configuration: the tolerance register sits at byte address zero.
  mag_t tol_q;
  logic cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == 4'd0);
  assign prdata = (paddr == 4'd0) ? {16'b0, tol_q} : 64'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= '0;
    end else if (cfg_wr) begin
      tol_q <= pwdata[47:0];
    end
  end

  // A beat enters every cycle that start is high.
  logic accept;
  mat_t mat_in;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign mat_in = {m_r2c2_i, m_r2c1_i, m_r2c0_i, m_r1c2_i, m_r1c1_i,
                   m_r1c0_i, m_r0c2_i, m_r0c1_i, m_r0c0_i};

  logic cof_valid;
  mat_t cof_mat;
  adj_t cof_adj;

  m3inv_cofactor u_cofactor (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept),
    .mat_i   (mat_in),
    .valid_o (cof_valid),
    .mat_o   (cof_mat),
    .adj_o   (cof_adj)
  );

  logic det_valid, det_neg, det_sing;
  adj_t det_adj;
  mag_t det_mag;

  m3inv_det u_det (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (cof_valid),
    .mat_i   (cof_mat),
    .adj_i   (cof_adj),
    .tol_i   (tol_q),
    .valid_o (det_valid),
    .adj_o   (det_adj),
    .dmag_o  (det_mag),
    .dneg_o  (det_neg),
    .sing_o  (det_sing)
  );

  // Nine independent divide lanes share the determinant magnitude.
  inv_t               lane_inv  [NumEntries];
  logic [NumEntries-1:0] lane_clip;

  for (genvar k = 0; k < NumEntries; k++) begin : g_lane
    m3inv_div_lane u_lane (
      .clk_i  (clk_i),
      .cof_i  (det_adj[k]),
      .dmag_i (det_mag),
      .dneg_i (det_neg),
      .inv_o  (lane_inv[k]),
      .clip_o (lane_clip[k])
    );
  end

  // Valid and singular flags ride alongside the lanes.
  logic [LaneDepth-1:0] vld_q;
  logic [LaneDepth-1:0] sing_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[LaneDepth-2:0], det_valid};
    end
  end

  always_ff @(posedge clk_i) begin
    sing_q <= {sing_q[LaneDepth-2:0], det_sing};
  end

  // Output register: a singular matrix gives all zeros with invertible_o and clipped_o low.
  logic lane_sing;
  inv_t out_q [NumEntries];
  logic done_q, inv_ok_q, clip_q;

  assign lane_sing = sing_q[LaneDepth-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= vld_q[LaneDepth-1];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NumEntries; k++) begin
      out_q[k] <= lane_sing ? '0 : lane_inv[k];
    end
    inv_ok_q <= !lane_sing;
    clip_q   <= !lane_sing && (|lane_clip);
  end

  assign done_o       = done_q;
  assign invertible_o = inv_ok_q;
  assign clipped_o    = clip_q;
  assign inv_r0c0_o   = out_q[0];
  assign inv_r0c1_o   = out_q[1];
  assign inv_r0c2_o   = out_q[2];
  assign inv_r1c0_o   = out_q[3];
  assign inv_r1c1_o   = out_q[4];
  assign inv_r1c2_o   = out_q[5];
  assign inv_r2c0_o   = out_q[6];
  assign inv_r2c1_o   = out_q[7];
  assign inv_r2c2_o   = out_q[8];

  `M3INV_ASSERT_IMPL(a_clip_needs_inv, clk_i, rst_ni, done_o && clipped_o, invertible_o)
  `M3INV_ASSERT_IMPL(a_sing_zero, clk_i, rst_ni, done_o && !invertible_o, inv_r1c1_o == 32'sd0)
  `M3INV_ASSERT_NEXT(a_lane_to_done, clk_i, rst_ni, vld_q[LaneDepth-1], done_o)

endmodule
